### rtl/dqs_pkg.sv
// ----------------------------------------------------------------------------
// dqs_pkg: shared constants for the deque with search
// Sizes, request mode codes and response status codes.
// ----------------------------------------------------------------------------
package dqs_pkg;

   localparam int CAPACITY    = 16;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   localparam int MODE_W      = 3;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 8;
   localparam int STATUS_W    = 2;
   localparam int FOUND_W     = 4;
   localparam int COUNT_OUT_W = 5;

   localparam int POS_CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int REQ_TDATA_W = 40;   // value, position
   localparam int RSP_TDATA_W = 48;   // value, found position, count, pad

   // request modes
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIND       = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ       = 3'd5;

   // response status
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

### rtl/dqs_ram.sv
// ----------------------------------------------------------------------------
// dqs_ram: generic single-port RAM
// One read or write per cycle, read data registered (read-first).
// ----------------------------------------------------------------------------
module dqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/dqs_slot.sv
// ----------------------------------------------------------------------------
// dqs_slot: ring address unit
// Slot of the entry at an offset from the head, wrapped at capacity.
// ----------------------------------------------------------------------------
module dqs_slot (
   input  logic [dqs_pkg::IDX_W-1:0] head,
   input  logic [dqs_pkg::IDX_W-1:0] offset,
   output logic [dqs_pkg::IDX_W-1:0] slot
);

   logic [dqs_pkg::IDX_W:0] sum;
   logic [dqs_pkg::IDX_W:0] wrapped;

   always_comb begin
      sum     = {1'b0, head} + {1'b0, offset};
      wrapped = sum - (dqs_pkg::IDX_W + 1)'(dqs_pkg::CAPACITY);
      if (sum >= (dqs_pkg::IDX_W + 1)'(dqs_pkg::CAPACITY)) begin
         slot = wrapped[dqs_pkg::IDX_W-1:0];
      end else begin
         slot = sum[dqs_pkg::IDX_W-1:0];
      end
   end

endmodule

### rtl/deque_with_search.sv
// ----------------------------------------------------------------------------
// deque_with_search: bounded double-ended queue with linear search
// Ring of CAPACITY signed 32-bit entries in a single-port RAM, addressed
// through one shared ring adder, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: push and any request answered from head/count alone finish in
//   EXEC; pop and read pass through READ_WAIT; find steps through SCAN until
//   it matches an entry or has compared the last stored one.
// Throughput: one request at a time; the next is taken once the sequencer
//   is back in IDLE after the response is loaded. The single
//   RAM port (one entry per cycle) sets the find time.
// Reset: head and count cleared, no response pending; RAM contents are
//   left as they are (no clearing pass), entries are used only once written.
// ----------------------------------------------------------------------------
module deque_with_search (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] data_value, [39:32] position
   input  logic [dqs_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // [2:0] mode
   input  logic [dqs_pkg::MODE_W-1:0]           req_tuser,

   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] result_value, [35:32] found_position, [40:36] entry_count,
   // [47:41] zero
   output logic [dqs_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [dqs_pkg::STATUS_W-1:0]         rsp_tuser
);

   typedef enum logic [1:0] {
      IDLE,
      EXEC,        // decide, write on push, issue first read
      READ_WAIT,   // pop / read data back from RAM
      SCAN         // find: compare one entry per cycle
   } state_type;

   state_type                            state_ff, state_in;

   // latched request
   logic [dqs_pkg::MODE_W-1:0]           mode_ff, mode_in;
   logic [dqs_pkg::VALUE_W-1:0]          value_ff, value_in;
   logic [dqs_pkg::POS_W-1:0]            pos_ff, pos_in;

   // ring state
   logic [dqs_pkg::IDX_W-1:0]            head_ff, head_in;
   logic [dqs_pkg::CNT_W-1:0]            count_ff, count_in;
   logic [dqs_pkg::IDX_W-1:0]            idx_ff, idx_in;

   // response register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [dqs_pkg::STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [dqs_pkg::VALUE_W-1:0]          rsp_value_ff, rsp_value_in;
   logic [dqs_pkg::FOUND_W-1:0]          rsp_found_ff, rsp_found_in;
   logic [dqs_pkg::COUNT_OUT_W-1:0]      rsp_count_ff, rsp_count_in;

   // finish strobe and its payload, set by the sequencer
   logic                                 fin;
   logic [dqs_pkg::STATUS_W-1:0]         fin_status;
   logic [dqs_pkg::VALUE_W-1:0]          fin_value;
   logic [dqs_pkg::IDX_W-1:0]            fin_found;

   // shared ring adder and RAM port
   logic [dqs_pkg::IDX_W-1:0]            offset;
   logic [dqs_pkg::IDX_W-1:0]            slot;
   logic                                 ram_we;
   logic [dqs_pkg::VALUE_W-1:0]          ram_rdata;

   logic                                 out_free;
   logic                                 is_full;
   logic                                 is_empty;
   logic [dqs_pkg::CNT_W-1:0]            count_dec;
   logic                                 scan_last;
   logic                                 pos_beyond;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_full    = (count_ff == dqs_pkg::CNT_W'(dqs_pkg::CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign count_dec  = count_ff - dqs_pkg::CNT_W'(1);
   assign scan_last  = ((dqs_pkg::CNT_W'(idx_ff) + dqs_pkg::CNT_W'(1)) == count_ff);
   assign pos_beyond = (dqs_pkg::POS_CMP_W'(pos_ff) >= dqs_pkg::POS_CMP_W'(count_ff));

   dqs_slot u_slot (
      .head   (head_ff),
      .offset (offset),
      .slot   (slot)
   );

   dqs_ram #(
      .WIDTH (dqs_pkg::VALUE_W),
      .DEPTH (dqs_pkg::CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (slot),
      .wdata (value_ff),
      .rdata (ram_rdata)
   );

   // Offset into the ring for the shared adder. In EXEC it picks the slot
   // each mode touches first; READ_WAIT reuses it to step the head; SCAN
   // reads one entry ahead of the one being compared.
   always_comb begin
      offset = '0;
      unique case (state_ff)
         EXEC: begin
            case (mode_ff)
               dqs_pkg::MODE_PUSH_FRONT: offset = dqs_pkg::IDX_W'(dqs_pkg::CAPACITY - 1);
               dqs_pkg::MODE_PUSH_BACK:  offset = count_ff[dqs_pkg::IDX_W-1:0];
               dqs_pkg::MODE_POP_BACK:   offset = count_dec[dqs_pkg::IDX_W-1:0];
               dqs_pkg::MODE_READ:       offset = pos_ff[dqs_pkg::IDX_W-1:0];
               default:                  offset = '0;
            endcase
         end
         READ_WAIT: offset = dqs_pkg::IDX_W'(1);
         SCAN:      offset = idx_ff + dqs_pkg::IDX_W'(1);
         default:   offset = '0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      value_in   = value_ff;
      pos_in     = pos_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      ram_we     = 1'b0;
      fin        = 1'b0;
      fin_status = dqs_pkg::ST_OK;
      fin_value  = '0;
      fin_found  = '0;

      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tuser;
               value_in = req_tdata[31:0];
               pos_in   = req_tdata[39:32];
               state_in = EXEC;
            end
         end

         EXEC: begin
            // hold until the response register can take a result
            if (out_free) begin
               case (mode_ff) inside
                  dqs_pkg::MODE_PUSH_FRONT: begin
                     fin = 1'b1;
                     if (is_full) begin
                        fin_status = dqs_pkg::ST_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        head_in  = slot;
                        count_in = count_ff + dqs_pkg::CNT_W'(1);
                     end
                  end
                  dqs_pkg::MODE_PUSH_BACK: begin
                     fin = 1'b1;
                     if (is_full) begin
                        fin_status = dqs_pkg::ST_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + dqs_pkg::CNT_W'(1);
                     end
                  end
                  dqs_pkg::MODE_POP_FRONT, dqs_pkg::MODE_POP_BACK: begin
                     if (is_empty) begin
                        fin        = 1'b1;
                        fin_status = dqs_pkg::ST_EMPTY;
                     end else begin
                        state_in = READ_WAIT;
                     end
                  end
                  dqs_pkg::MODE_FIND: begin
                     if (is_empty) begin
                        fin        = 1'b1;
                        fin_status = dqs_pkg::ST_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = SCAN;
                     end
                  end
                  dqs_pkg::MODE_READ: begin
                     if (is_empty) begin
                        fin        = 1'b1;
                        fin_status = dqs_pkg::ST_EMPTY;
                     end else if (pos_beyond) begin
                        fin        = 1'b1;
                        fin_status = dqs_pkg::ST_NOT_FOUND;
                     end else begin
                        state_in = READ_WAIT;
                     end
                  end
                  default: begin
                     // unused modes: no change, plain ok
                     fin = 1'b1;
                  end
               endcase
            end
         end

         READ_WAIT: begin
            fin       = 1'b1;
            fin_value = ram_rdata;
            if (mode_ff == dqs_pkg::MODE_POP_FRONT) begin
               head_in  = slot;
               count_in = count_dec;
            end else if (mode_ff == dqs_pkg::MODE_POP_BACK) begin
               count_in = count_dec;
            end
         end

         SCAN: begin
            // ram_rdata holds the entry at position idx_ff
            if (ram_rdata == value_ff) begin
               fin       = 1'b1;
               fin_value = value_ff;
               fin_found = idx_ff;
            end else if (scan_last) begin
               fin        = 1'b1;
               fin_status = dqs_pkg::ST_NOT_FOUND;
            end else begin
               idx_in = idx_ff + dqs_pkg::IDX_W'(1);
            end
         end

         default: state_in = IDLE;
      endcase

      if (fin) begin
         state_in = IDLE;
      end
   end

   // Response register: freed on take, loaded on finish
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (fin) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_value_in  = fin_value;
         rsp_found_in  = dqs_pkg::FOUND_W'(fin_found);
         rsp_count_in  = dqs_pkg::COUNT_OUT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_found_ff, rsp_value_ff};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dqs_pkg::CNT_W'(dqs_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == EXEC))
      else $error("accepted request did not enter execution");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN) |-> (dqs_pkg::CNT_W'(idx_ff) < count_ff))
      else $error("search index beyond stored entries");

   a_write_not_full: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !is_full)
      else $error("RAM write while full");

endmodule

### tb/deque_with_search_checker.sv
// ----------------------------------------------------------------------------
// deque_with_search_checker: response predictor and scoreboard
// Watches both stream channels, keeps its own copy of the ring, and compares
// every response field by field with the oldest predicted answer.
// ----------------------------------------------------------------------------
module deque_with_search_checker
   import dqs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // [31:0] data_value, [39:32] position
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [2:0] mode
   input  logic [MODE_W-1:0]      req_tuser,

   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] result_value, [35:32] found_position, [40:36] entry_count,
   // [47:41] zero
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] status
   input  logic [STATUS_W-1:0]    rsp_tuser,

   output int                     fail_count,
   output int                     outstanding
);

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [VALUE_W-1:0]     value;
      logic [FOUND_W-1:0]     found_pos;
      logic [COUNT_OUT_W-1:0] count;
   } deque_answer_type;

   logic [VALUE_W-1:0] slot_mem [CAPACITY];
   logic [IDX_W-1:0]   front_slot;
   logic [CNT_W-1:0]   fill_level;
   deque_answer_type   answer_q [$];
   int                 rsp_seen;

   function automatic int slot_of(input int offset);
      return (int'(front_slot) + offset) % CAPACITY;
   endfunction

   // one line per mismatch, and count it
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      $display("%0t checker: response %0d %s: got %0h, want %0h",
               $time, rsp_seen, what, got, want);
   endtask

   task automatic predict_answer(input logic [MODE_W-1:0] mode,
                                 input logic [VALUE_W-1:0] value,
                                 input logic [POS_W-1:0] pos,
                                 output deque_answer_type ans);
      int  scan;
      bit  hit;
      ans        = '0;
      ans.status = ST_OK;
      case (mode) inside
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (fill_level >= CAPACITY) begin
               ans.status = ST_FULL;
            end else if (mode == MODE_PUSH_FRONT) begin
               front_slot = IDX_W'((int'(front_slot) + CAPACITY - 1) % CAPACITY);
               slot_mem[front_slot] = value;
               fill_level++;
            end else begin
               slot_mem[slot_of(int'(fill_level))] = value;
               fill_level++;
            end
         end
         MODE_POP_FRONT: begin
            if (fill_level == 0) begin
               ans.status = ST_EMPTY;
            end else begin
               ans.value  = slot_mem[front_slot];
               front_slot = IDX_W'((int'(front_slot) + 1) % CAPACITY);
               fill_level--;
            end
         end
         MODE_POP_BACK: begin
            if (fill_level == 0) begin
               ans.status = ST_EMPTY;
            end else begin
               ans.value = slot_mem[slot_of(int'(fill_level) - 1)];
               fill_level--;
            end
         end
         MODE_FIND: begin
            if (fill_level == 0) begin
               ans.status = ST_EMPTY;
            end else begin
               // first match from the front wins
               hit  = 1'b0;
               scan = 0;
               while (!hit && scan < int'(fill_level)) begin
                  if (slot_mem[slot_of(scan)] == value) begin
                     hit           = 1'b1;
                     ans.value     = value;
                     ans.found_pos = FOUND_W'(scan);
                  end
                  scan++;
               end
               ans.status = hit ? ST_OK : ST_NOT_FOUND;
            end
         end
         MODE_READ: begin
            if (fill_level == 0)
               ans.status = ST_EMPTY;
            else if (pos >= fill_level)
               ans.status = ST_NOT_FOUND;
            else
               ans.value = slot_mem[slot_of(int'(pos))];
         end
         default: ;
      endcase
      ans.count = COUNT_OUT_W'(fill_level);
   endtask

   always @(posedge clock) begin : scoreboard
      deque_answer_type want, fresh;
      if (reset) begin
         front_slot = '0;
         fill_level = '0;
         answer_q.delete();
         outstanding <= 0;
      end else begin
         // responses first: a request accepted now cannot answer on this edge
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               report_mismatch("with nothing pending", rsp_tdata, 0);
            end else begin
               want = answer_q.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, want.status);
               if (rsp_tdata[31:0] !== want.value)
                  report_mismatch("result_value", rsp_tdata[31:0], want.value);
               if (rsp_tdata[35:32] !== want.found_pos)
                  report_mismatch("found_position", rsp_tdata[35:32], want.found_pos);
               if (rsp_tdata[40:36] !== want.count)
                  report_mismatch("entry_count", rsp_tdata[40:36], want.count);
               if (rsp_tdata[47:41] !== '0)
                  report_mismatch("pad bits", rsp_tdata[47:41], 0);
            end
            rsp_seen++;
         end
         if (req_tvalid && req_tready) begin
            predict_answer(req_tuser, req_tdata[31:0], req_tdata[39:32], fresh);
            answer_q.push_back(fresh);
         end
         outstanding <= answer_q.size();
      end
   end

endmodule

### tb/deque_with_search_tb.sv
// ----------------------------------------------------------------------------
// deque_with_search_tb: stimulus and verdict for the deque with search
// Directed corner requests, then random bursts (fill, drain, mixed, noise)
// under four idling phases, with a long response hold-off that backs up the
// request channel. A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module deque_with_search_tb;
   import dqs_pkg::*;

   // modes the block must answer as no-ops
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam int HOLD_CYCLES  = 400;            // long response hold-off
   localparam int RANDOM_ITEMS = 1080;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED, BURST_NOISE} burst_kind_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [31:0] data_value, [39:32] position
   logic [MODE_W-1:0]      req_tuser  = '0;   // [2:0] mode

   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [31:0] value, [35:32] found pos,
                                              // [40:36] count, [47:41] zero
   logic [STATUS_W-1:0]    rsp_tuser;         // [1:0] status

   int                     fail_count;
   int                     outstanding;

   int                     send_gap_pct = 0;  // chance of a gap before a request
   int                     stall_pct    = 0;  // chance of rsp_tready low per cycle
   logic                   rsp_hold     = 1'b0;
   event                   hold_kick;

   int                     items_sent   = 0;
   logic [VALUE_W-1:0]     value_pool [8];    // recently pushed values, for finds
   int                     pool_wr      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   deque_with_search uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   deque_with_search_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Response side: random stalls, forced low for the whole hold-off.
   always @(posedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
   end

   // Hold-off counter lives in its own process so the sender keeps offering.
   initial begin
      forever begin
         @(hold_kick);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // Offer one request and return on the edge that accepts it. Valid stays
   // high straight into the next request unless a gap is drawn.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [VALUE_W-1:0] value,
                               input logic [POS_W-1:0] pos);
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pos, value};
      req_tuser  <= mode;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK) begin
         value_pool[pool_wr] = value;
         pool_wr = (pool_wr + 1) % 8;
      end
      items_sent++;
   endtask

   // Drop valid and wait until every pending response has been taken.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Extremes, pushed values (duplicates likely) and plain random words.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return '0;
         3:       return '1;
         4, 5, 6: return value_pool[$urandom_range(7)];
         default: return $urandom();
      endcase
   endfunction

   // Mostly around the live range, sometimes anywhere in the byte.
   function automatic logic [POS_W-1:0] pick_pos();
      if ($urandom_range(4) == 0)
         return POS_W'($urandom());
      return POS_W'($urandom_range(0, CAPACITY + 1));
   endfunction

   task automatic run_burst(input burst_kind_type kind);
      int                len;
      int                pick;
      logic [MODE_W-1:0] mode;
      case (kind)
         // run the ring past full so overpushes answer full
         BURST_FILL: begin
            len = $urandom_range(CAPACITY - 4, CAPACITY + 4);
            repeat (len)
               send_request($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT,
                            pick_value(), pick_pos());
         end
         // mostly pops down past empty, with lookups sprinkled in
         BURST_DRAIN: begin
            len = $urandom_range(CAPACITY - 4, CAPACITY + 4);
            repeat (len) begin
               pick = $urandom_range(9);
               if (pick < 6)
                  mode = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
               else if (pick < 8)
                  mode = MODE_FIND;
               else
                  mode = MODE_READ;
               send_request(mode, pick_value(), pick_pos());
            end
         end
         BURST_MIXED: begin
            len = $urandom_range(10, 40);
            repeat (len) begin
               pick = $urandom_range(99);
               if (pick < 18)      mode = MODE_PUSH_FRONT;
               else if (pick < 36) mode = MODE_PUSH_BACK;
               else if (pick < 48) mode = MODE_POP_FRONT;
               else if (pick < 60) mode = MODE_POP_BACK;
               else if (pick < 78) mode = MODE_FIND;
               else if (pick < 95) mode = MODE_READ;
               else                mode = $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
               send_request(mode, pick_value(), pick_pos());
            end
         end
         // fully random fields, unused modes included
         default: begin
            len = $urandom_range(3, 8);
            repeat (len)
               send_request(MODE_W'($urandom()), $urandom(), POS_W'($urandom()));
         end
      endcase
   endtask

   initial begin : stimulus
      int             gap_by_phase   [4];
      int             stall_by_phase [4];
      int             target;
      int             pick;
      burst_kind_type kind;

      gap_by_phase   = '{0, 48, 0, 25};
      stall_by_phase = '{0, 0, 48, 25};
      // small seed values so random finds hit duplicates
      for (int i = 0; i < 8; i++)
         value_pool[i] = VALUE_W'($urandom_range(0, 15));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed: empty cases, extremes, lookups, unused modes ---
      send_request(MODE_POP_FRONT, '0, '0);
      send_request(MODE_POP_BACK,  '0, '0);
      send_request(MODE_FIND,      '0, '0);
      send_request(MODE_READ,      '0, '0);
      send_request(MODE_SPARE_LO,  '0, '0);
      send_request(MODE_SPARE_HI,  '1, '1);
      // ring becomes 0, min, max, -1
      send_request(MODE_PUSH_FRONT, 32'h8000_0000, '0);
      send_request(MODE_PUSH_BACK,  32'h7FFF_FFFF, '0);
      send_request(MODE_PUSH_FRONT, 32'h0000_0000, '0);
      send_request(MODE_PUSH_BACK,  32'hFFFF_FFFF, '0);
      send_request(MODE_READ, '0, 8'd0);
      send_request(MODE_READ, '0, 8'd3);
      send_request(MODE_READ, '0, 8'd4);            // just past the count
      send_request(MODE_READ, '0, 8'hFF);
      send_request(MODE_FIND, 32'h7FFF_FFFF, '0);
      send_request(MODE_FIND, 32'h1234_5678, '0);   // no match
      send_request(MODE_FIND, 32'hFFFF_FFFF, '0);   // last entry
      send_request(MODE_PUSH_BACK, 32'h0000_0000, '0);
      send_request(MODE_FIND, 32'h0000_0000, '0);   // duplicate: front one wins
      send_request(MODE_SPARE_LO, 32'hDEAD_BEEF, 8'h5A);
      send_request(MODE_POP_FRONT, '0, '0);
      send_request(MODE_POP_BACK,  '0, '0);
      send_request(MODE_POP_FRONT, '0, '0);
      send_request(MODE_POP_BACK,  '0, '0);
      send_request(MODE_POP_BACK,  '0, '0);
      wait_for_quiet();

      // --- back-pressure: responses held while requests keep coming ---
      -> hold_kick;
      repeat (12)
         send_request($urandom_range(1) ? MODE_PUSH_BACK : MODE_FIND,
                      pick_value(), pick_pos());
      wait_for_quiet();

      // --- random bursts, one idling profile per phase ---
      for (int phase = 0; phase < 4; phase++) begin
         send_gap_pct = gap_by_phase[phase];
         stall_pct   <= stall_by_phase[phase];
         target       = items_sent + RANDOM_ITEMS / 4;
         while (items_sent < target) begin
            pick = $urandom_range(9);
            if (pick < 3)      kind = BURST_FILL;
            else if (pick < 5) kind = BURST_DRAIN;
            else if (pick < 9) kind = BURST_MIXED;
            else               kind = BURST_NOISE;
            run_burst(kind);
         end
         // sender pauses until every response is in
         wait_for_quiet();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("** deque_with_search: PASSED **");
      else
         $display("** deque_with_search: FAILED **");
      $finish;
   end

   // Watchdog: many times the slowest legal run.
   initial begin
      #5_000_000;
      $display("** deque_with_search: FAILED **");
      $finish;
   end

endmodule

### sim.f
rtl/dqs_pkg.sv
rtl/dqs_ram.sv
rtl/dqs_slot.sv
rtl/deque_with_search.sv
tb/deque_with_search_checker.sv
tb/deque_with_search_tb.sv
